[sv/sequenced_checksum_packetizer_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sequenced checksum packetizer
// Shared property forms; every macro samples on clk and expects rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_CHECKSUM_PACKETIZER_DEFINES_SVH
`define SEQUENCED_CHECKSUM_PACKETIZER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SCP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// State in the cycle after any cycle held in reset.
`define SCP_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

[sv/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// Constants and types shared by the packetizer front end, queue and back end.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int MAX_CHUNK   = 32;
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int SEQ_W       = 32;
  localparam int HDR_BYTES   = 5;
  localparam int QDEPTH      = 2;
  localparam int SLOT_W      = $clog2(QDEPTH);
  localparam int CNT_W       = $clog2(QDEPTH + 1);
  localparam int IDX_W       = $clog2(MAX_CHUNK);
  localparam int ADDR_W      = SLOT_W + IDX_W;
  localparam int BUF_DEPTH   = 1 << ADDR_W;
  localparam int POS_W       = $clog2(MAX_CHUNK + HDR_BYTES);
  localparam int HB_W        = $clog2(HDR_BYTES);
  localparam int CHUNK_RESET = 32;

  localparam logic FUNC_DATA    = 1'b0;
  localparam logic FUNC_CONNECT = 1'b1;

  // One closed packet waiting for the back end
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [BYTE_W-1:0] csum;
    logic [LEN_W-1:0]  len;
    logic              msg_last;
  } desc_t;

  typedef struct packed {
    logic              full;
    logic              valid;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
  } q_stat_t;

endpackage

[sv/scp_pkt_buf.sv]
// ----------------------------------------------------------------------------
// scp_pkt_buf
// Payload buffer, one bank per queue slot; one write and one registered read.
// ----------------------------------------------------------------------------
module scp_pkt_buf (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [scp_pkg::ADDR_W-1:0] wr_addr,
  input  logic [scp_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [scp_pkg::ADDR_W-1:0] rd_addr,
  output logic [scp_pkg::BYTE_W-1:0] rd_data
);
  import scp_pkg::*;

  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read while the output stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/scp_desc_queue.sv]
// ----------------------------------------------------------------------------
// scp_desc_queue
// Short queue of closed packet descriptors; an entry leaves after its last byte.
// ----------------------------------------------------------------------------
module scp_desc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  scp_pkg::desc_t   push_desc,
  input  logic             pop,
  output scp_pkg::desc_t   head,
  output scp_pkg::q_stat_t stat
);
  import scp_pkg::*;

  desc_t             desc_r [QDEPTH];
  logic [SLOT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [SLOT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == SLOT_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == SLOT_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      desc_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head         = desc_r[rd_ptr_r];
  assign stat.full    = (count_r == CNT_W'(QDEPTH));
  assign stat.valid   = (count_r != '0);
  assign stat.wr_slot = wr_ptr_r;
  assign stat.rd_slot = rd_ptr_r;

endmodule

[sv/scp_front.sv]
// ----------------------------------------------------------------------------
// scp_front
// Accepts stream items, buffers payload, closes packets and numbers them.
// ----------------------------------------------------------------------------
module scp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [scp_pkg::LEN_W-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [scp_pkg::BYTE_W-1:0] in_tdata,
  input  logic                       in_tuser,
  input  logic                       in_tlast,
  input  scp_pkg::q_stat_t           q_stat,
  output logic                       push,
  output scp_pkg::desc_t             push_desc,
  output logic                       wr_en,
  output logic [scp_pkg::ADDR_W-1:0] wr_addr,
  output logic [scp_pkg::BYTE_W-1:0] wr_data
);
  import scp_pkg::*;

  logic [LEN_W-1:0]  chunk_r;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  fill_inc;
  logic [BYTE_W-1:0] xor_upd;
  logic              acc;
  logic              close;

  always_comb begin
    if (chunk_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (chunk_r > LEN_W'(MAX_CHUNK)) begin
      eff_len = LEN_W'(MAX_CHUNK);
    end else begin
      eff_len = chunk_r;
    end
  end

  // A free bank always exists while the queue has room
  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign fill_inc  = fill_r + 1'b1;
  assign xor_upd   = xor_r ^ in_tdata;
  assign close     = (fill_inc >= eff_len) || in_tlast;

  assign wr_en   = acc && (in_tuser == FUNC_DATA);
  assign wr_addr = {q_stat.wr_slot, fill_r[IDX_W-1:0]};
  assign wr_data = in_tdata;

  assign push               = wr_en && close;
  assign push_desc.seq      = seq_r;
  assign push_desc.csum     = xor_upd;
  assign push_desc.len      = fill_inc;
  assign push_desc.msg_last = in_tlast;

  always_comb begin
    fill_nxt = fill_r;
    xor_nxt  = xor_r;
    seq_nxt  = seq_r;
    if (acc && (in_tuser == FUNC_CONNECT)) begin
      seq_nxt = '0;
    end else if (wr_en) begin
      if (close) begin
        fill_nxt = '0;
        xor_nxt  = '0;
        seq_nxt  = seq_r + 1'b1;
      end else begin
        fill_nxt = fill_inc;
        xor_nxt  = xor_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= LEN_W'(CHUNK_RESET);
      fill_r  <= '0;
      xor_r   <= '0;
      seq_r   <= '0;
    end else begin
      if (cfg_we) begin
        chunk_r <= cfg_wdata;
      end
      fill_r <= fill_nxt;
      xor_r  <= xor_nxt;
      seq_r  <= seq_nxt;
    end
  end

endmodule

[sv/scp_back.sv]
// ----------------------------------------------------------------------------
// scp_back
// Walks the head packet: four sequence bytes, checksum, then buffered payload.
// ----------------------------------------------------------------------------
module scp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scp_pkg::q_stat_t           q_stat,
  input  scp_pkg::desc_t             head,
  output logic                       pop,
  output logic                       rd_en,
  output logic [scp_pkg::ADDR_W-1:0] rd_addr,
  input  logic [scp_pkg::BYTE_W-1:0] rd_data,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [scp_pkg::BYTE_W-1:0] out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);
  import scp_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r;
  logic              src_pay_r;
  logic [BYTE_W-1:0] hdr_r;
  logic              tlast_r;
  logic              tuser_r;

  logic                            load;
  logic                            emit;
  logic                            is_pay;
  logic                            last_b;
  logic [POS_W-1:0]                pay_pos;
  logic [HB_W-1:0]                 hsel;
  logic [HDR_BYTES-1:0][BYTE_W-1:0] hdr_bytes;

  assign load    = !out_valid_r || out_tready;
  assign emit    = load && q_stat.valid;
  assign is_pay  = (pos_r >= POS_W'(HDR_BYTES));
  assign last_b  = (pos_r == POS_W'(head.len) + POS_W'(HDR_BYTES - 1));
  assign pay_pos = pos_r - POS_W'(HDR_BYTES);

  // Sequence number big-endian first, checksum in the lowest slot
  assign hdr_bytes = {head.seq, head.csum};
  assign hsel      = HB_W'(HDR_BYTES - 1) - pos_r[HB_W-1:0];

  assign rd_en   = emit && is_pay;
  assign rd_addr = {q_stat.rd_slot, pay_pos[IDX_W-1:0]};
  assign pop     = emit && last_b;

  always_comb begin
    pos_nxt = pos_r;
    if (emit) begin
      pos_nxt = last_b ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= q_stat.valid;
      end
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      src_pay_r <= is_pay;
      hdr_r     <= hdr_bytes[hsel];
      tlast_r   <= last_b;
      tuser_r   <= last_b && head.msg_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = src_pay_r ? rd_data : hdr_r;
  assign out_tlast  = tlast_r;
  assign out_tuser  = tuser_r;

endmodule

[sv/sequenced_checksum_packetizer.sv]
// ----------------------------------------------------------------------------
// sequenced_checksum_packetizer
// Cuts a byte stream into numbered, checksummed packets.
// ----------------------------------------------------------------------------
// Input stream: one message byte per transaction on in_tdata, in_tlast on the
// final byte of a message; in_tuser high makes the transaction a connect,
// which clears the packet sequence number and carries no byte.
// Output stream: one packet byte per transaction: sequence number (4 bytes,
// MSB first), XOR of the payload, then the payload. out_tlast marks the last
// byte of each packet, out_tuser the last byte of a message's final packet.
// cfg_we/cfg_wdata set the payload length per packet (0 acts as 1, values
// above 32 act as 32); write it only while the block is idle.
// The first header byte is registered once the descriptor of the packet that
// closes has entered the queue. The back end sends one byte per cycle while
// out_tready allows, so a packet of N payload bytes goes out as N+5 bytes; input
// is taken one byte per cycle while one of the two payload banks is free, so for
// long messages input is held to N payload bytes per N+5 output bytes.
// Reset clears sequence number, fill level, checksum and queue, and restores
// a payload length of 32. A stalled receiver holds the current output byte;
// input keeps flowing until both banks hold closed packets.
// ----------------------------------------------------------------------------
module sequenced_checksum_packetizer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [scp_pkg::LEN_W-1:0]  cfg_wdata,   // chunk_length
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [scp_pkg::BYTE_W-1:0] in_tdata,    // data_byte
  input  logic                       in_tuser,    // func
  input  logic                       in_tlast,    // last_byte
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [scp_pkg::BYTE_W-1:0] out_tdata,   // out_byte
  output logic                       out_tuser,   // message_end
  output logic                       out_tlast    // packet_end
);
  import scp_pkg::*;

  q_stat_t           q_stat;
  desc_t             push_desc;
  desc_t             head;
  logic              push;
  logic              pop;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  scp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  scp_desc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  scp_pkt_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[sv/scp_checker.sv]
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks on the packetizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "sequenced_checksum_packetizer_defines.svh"

module scp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_we,
  input logic [scp_pkg::LEN_W-1:0]  cfg_wdata,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [scp_pkg::BYTE_W-1:0] in_tdata,
  input logic                       in_tuser,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [scp_pkg::BYTE_W-1:0] out_tdata,
  input logic                       out_tuser,
  input logic                       out_tlast
);

  // Stalled output keeps its transaction
  `SCP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out_tvalid dropped")
  `SCP_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "out_tdata moved")

  // Message end only ever lands on a packet end
  `SCP_ASSERT_SAME(a_msg_end, out_tvalid && out_tuser, out_tlast, "message end off packet end")

  // A packet always carries a header, so two packet ends never follow back to back
  `SCP_ASSERT_NEXT(a_pkt_gap, out_tvalid && out_tready && out_tlast,
                   !(out_tvalid && out_tlast), "packet end right after packet end")

  // Reset empties the queue and output register
  `SCP_ASSERT_RST(a_rst_state, !out_tvalid && in_tready, "not idle after reset")

endmodule

bind sequenced_checksum_packetizer scp_checker u_chk (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packetizer stream testbench
// Feeds message bytes and connect transactions into the packetizer under
// several payload lengths, predicts every packet byte (sequence number,
// XOR checksum, payload, end flags) and compares the output stream in order.
// ----------------------------------------------------------------------------
module tb_top;

  import scp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  // Tracks the packetizer state and the packet bytes still owed by the block
  class packet_byte_tracker;
    typedef struct {
      bit [BYTE_W-1:0] value;
      bit              pkt_end;
      bit              msg_end;
    } pkt_byte_t;

    bit [BYTE_W-1:0] payload [MAX_CHUNK];
    int unsigned     fill;
    bit [BYTE_W-1:0] xor_acc;
    bit [SEQ_W-1:0]  seq_no;
    bit [LEN_W-1:0]  chunk_reg;
    pkt_byte_t       owed_bytes [$];
    int              errors;

    function new();
      chunk_reg = LEN_W'(CHUNK_RESET);
    endfunction

    function void set_chunk(bit [LEN_W-1:0] v);
      chunk_reg = v;
    endfunction

    function int unsigned packet_limit();
      int unsigned len;
      len = 32'(chunk_reg);
      if (len == 0) len = 1;
      if (len > MAX_CHUNK) len = MAX_CHUNK;
      return len;
    endfunction

    function void push_byte(bit [BYTE_W-1:0] v, bit pe, bit me);
      pkt_byte_t e;
      e.value = v;
      e.pkt_end = pe;
      e.msg_end = me;
      owed_bytes.push_back(e);
    endfunction

    // Note one accepted input transaction
    function void absorb_input(bit f, bit [BYTE_W-1:0] b, bit l);
      if (f == FUNC_CONNECT) begin
        seq_no = '0;
        return;
      end
      if (fill < MAX_CHUNK) begin
        payload[fill] = b;
        fill++;
      end
      xor_acc ^= b;
      if (fill < packet_limit() && !l) return;
      push_byte(seq_no[31:24], 1'b0, 1'b0);
      push_byte(seq_no[23:16], 1'b0, 1'b0);
      push_byte(seq_no[15:8], 1'b0, 1'b0);
      push_byte(seq_no[7:0], 1'b0, 1'b0);
      push_byte(xor_acc, 1'b0, 1'b0);
      for (int i = 0; i < fill; i++)
        push_byte(payload[i], i + 1 == fill, (i + 1 == fill) && l);
      fill = 0;
      xor_acc = '0;
      seq_no = seq_no + 1;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    // Compare one accepted output transaction with the oldest owed byte
    task match_output(bit [BYTE_W-1:0] v, bit pe, bit me);
      pkt_byte_t e;
      if (owed_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h", v));
        return;
      end
      e = owed_bytes.pop_front();
      if (v != e.value)
        report_mismatch($sformatf("byte %02h, want %02h", v, e.value));
      if (pe != e.pkt_end)
        report_mismatch($sformatf("packet end %0b, want %0b", pe, e.pkt_end));
      if (me != e.msg_end)
        report_mismatch($sformatf("message end %0b, want %0b", me, e.msg_end));
    endtask

    function int owed_count();
      return owed_bytes.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [LEN_W-1:0]  cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata;
  logic              in_tuser;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [BYTE_W-1:0] out_tdata;
  logic              out_tuser;
  logic              out_tlast;

  packet_byte_tracker tracker = new();
  bit                 quiet;
  int unsigned        cycles;

  sequenced_checksum_packetizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, check each accepted output transaction
  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        tracker.match_output(out_tdata, out_tlast, out_tuser);
      @(negedge clk);
      if (!rst_n) begin
        out_tready = 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready = 1'b0;
      end else begin
        stall = pick_gap();
        out_tready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Entered and left at a falling edge
  task automatic send_item(input logic f, input logic [BYTE_W-1:0] b, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = f;
    in_tdata = b;
    in_tlast = l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.absorb_input(f, b, l);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (tracker.owed_count() != 0) @(negedge clk);
  endtask

  // Write only with the block idle; hold off past the closing latency
  task automatic set_chunk(input logic [LEN_W-1:0] v);
    wait_drained();
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_chunk(v);
  endtask

  initial begin
    int plan [8];
    int phase_items;
    int msg_len;
    bit first_msg;
    logic [LEN_W-1:0] chunk;

    plan = '{2, 32, 0, 63, 7, 33, 1, 5};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_DATA;
    in_tlast = 1'b0;
    quiet = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: single-byte messages at the reset length, extremes of the byte
    send_item(FUNC_DATA, 8'h00, 1'b1);
    send_item(FUNC_DATA, 8'hFF, 1'b1);
    // Connect ignores its byte and last flag, restarts numbering
    send_item(FUNC_CONNECT, 8'hFF, 1'b1);
    send_item(FUNC_DATA, 8'hA5, 1'b1);
    // One-byte chunks, full chunk together with the last byte
    set_chunk(LEN_W'(1));
    send_item(FUNC_DATA, 8'h5A, 1'b0);
    send_item(FUNC_DATA, 8'h3C, 1'b0);
    send_item(FUNC_DATA, 8'hC3, 1'b1);
    // Zero length acts as one
    set_chunk(LEN_W'(0));
    send_item(FUNC_DATA, 8'h81, 1'b0);
    send_item(FUNC_DATA, 8'h7E, 1'b1);
    // Oversized length acts as the maximum
    set_chunk(LEN_W'(63));
    send_item(FUNC_DATA, 8'h12, 1'b0);
    send_item(FUNC_DATA, 8'h34, 1'b0);
    send_item(FUNC_DATA, 8'h56, 1'b1);
    // Connect inside a packet keeps the buffered payload
    set_chunk(LEN_W'(4));
    send_item(FUNC_DATA, 8'h01, 1'b0);
    send_item(FUNC_DATA, 8'h02, 1'b0);
    send_item(FUNC_CONNECT, 8'h00, 1'b0);
    send_item(FUNC_DATA, 8'h04, 1'b1);
    // Lower the length mid-packet: the next byte closes an oversize packet
    set_chunk(LEN_W'(32));
    send_item(FUNC_DATA, 8'h11, 1'b0);
    send_item(FUNC_DATA, 8'h22, 1'b0);
    set_chunk(LEN_W'(1));
    send_item(FUNC_DATA, 8'h33, 1'b0);

    // Random: one phase per length, mostly well-formed messages
    for (int p = 0; p < 8; p++) begin
      chunk = (p == 7) ? LEN_W'($urandom_range(0, 63)) : LEN_W'(plan[p]);
      set_chunk(chunk);
      quiet = (p == 1);
      phase_items = 0;
      first_msg = 1'b1;
      while (phase_items < 5) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(FUNC_CONNECT, BYTE_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
          phase_items++;
        end
        // One full-length message back to back at the maximum length
        if (first_msg && p == 1)
          msg_len = $urandom_range(32, 34);
        else if ($urandom_range(0, 3) == 0)
          msg_len = $urandom_range(6, 20);
        else
          msg_len = $urandom_range(1, 5);
        first_msg = 1'b0;
        for (int i = 0; i < msg_len; i++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(FUNC_CONNECT, BYTE_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          // Now and then drop the last flag so a message runs into the next
          send_item(FUNC_DATA, BYTE_W'($urandom_range(0, 255)),
                    (i == msg_len - 1) && ($urandom_range(0, 9) != 0));
          phase_items++;
        end
      end
      quiet = 1'b0;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (tracker.errors == 0 && tracker.owed_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
